[design/u8v_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package u8v_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_string;
    } t_in_item;

    typedef struct packed {
        logic [31:0] char_word;
        logic [2:0]  char_length;
        logic        char_matches;
        logic        bad_sequence;
        logic        string_done;
        logic        string_valid;
        logic        char_found;
    } t_out_item;

    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_ONE  = 3'd1;
    localparam logic [2:0] LEN_TWO  = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR = 3'd4;

    localparam logic [1:0] CONT_TAG    = 2'b10;
    localparam logic [4:0] ILLEGAL_TAG = 5'b11111;

endpackage

`default_nettype wire

[design/u8v_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module u8v_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire u8v_pkg::t_in_item  i_item,
    input  wire logic [31:0]        i_search_char,
    output logic                    o_res_valid,
    output u8v_pkg::t_out_item      o_res
);

    logic [23:0] r_partial;
    logic [2:0]  r_exp_len;
    logic [1:0]  r_taken;
    logic        r_error;
    logic        r_match;

    logic [23:0] n_partial;
    logic [2:0]  n_exp_len;
    logic [1:0]  n_taken;
    logic        n_error;
    logic        n_match;

    logic [7:0]  b;
    logic [31:0] word;
    logic [31:0] full;
    logic [2:0]  len;
    logic [2:0]  taken_inc;
    logic        bad;
    logic        matched;
    logic        truncated;

    always_comb begin
        b         = i_item.data_byte;
        word      = 32'd0;
        len       = u8v_pkg::LEN_NONE;
        bad       = 1'b0;
        matched   = 1'b0;
        truncated = 1'b0;
        n_partial = r_partial;
        n_exp_len = r_exp_len;
        n_taken   = r_taken;
        n_error   = r_error;
        n_match   = r_match;
        taken_inc = {1'b0, r_taken} + 3'd1;
        full      = {8'd0, r_partial} | ({24'd0, b} << {r_taken, 3'b000});

        if (!r_error) begin
            if (r_exp_len == u8v_pkg::LEN_NONE) begin
                if (!b[7]) begin
                    word = {24'd0, b};
                    len  = u8v_pkg::LEN_ONE;
                end else if (!b[6] || b[7:3] == u8v_pkg::ILLEGAL_TAG) begin
                    bad = 1'b1;
                end else begin
                    n_partial = {16'd0, b};
                    n_taken   = 2'd1;
                    if (!b[5]) begin
                        n_exp_len = u8v_pkg::LEN_TWO;
                    end else if (!b[4]) begin
                        n_exp_len = u8v_pkg::LEN_THREE;
                    end else begin
                        n_exp_len = u8v_pkg::LEN_FOUR;
                    end
                end
            end else if (b[7:6] != u8v_pkg::CONT_TAG) begin
                bad       = 1'b1;
                n_partial = 24'd0;
                n_exp_len = u8v_pkg::LEN_NONE;
                n_taken   = 2'd0;
            end else if (taken_inc >= r_exp_len) begin
                word      = full;
                len       = taken_inc;
                n_partial = 24'd0;
                n_exp_len = u8v_pkg::LEN_NONE;
                n_taken   = 2'd0;
            end else begin
                n_partial = full[23:0];
                n_taken   = taken_inc[1:0];
            end
            if (bad) begin
                n_error = 1'b1;
            end
            if (len != u8v_pkg::LEN_NONE && word == i_search_char) begin
                matched = 1'b1;
                n_match = 1'b1;
            end
        end

        o_res.char_word     = word;
        o_res.char_length   = len;
        o_res.char_matches  = matched;
        o_res.string_done   = i_item.end_of_string;
        o_res.string_valid  = 1'b0;
        o_res.char_found    = 1'b0;

        if (i_item.end_of_string) begin
            if (!n_error && n_exp_len != u8v_pkg::LEN_NONE) begin
                truncated = 1'b1;
            end
            o_res.string_valid = !n_error && !truncated;
            o_res.char_found   = n_match;
            n_partial = 24'd0;
            n_exp_len = u8v_pkg::LEN_NONE;
            n_taken   = 2'd0;
            n_error   = 1'b0;
            n_match   = 1'b0;
        end

        o_res.bad_sequence = bad || truncated;
        o_res_valid = i_accept
                   && (i_item.end_of_string || bad || len != u8v_pkg::LEN_NONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= 24'd0;
            r_exp_len <= u8v_pkg::LEN_NONE;
            r_taken   <= 2'd0;
            r_error   <= 1'b0;
            r_match   <= 1'b0;
        end else if (i_accept) begin
            r_partial <= n_partial;
            r_exp_len <= n_exp_len;
            r_taken   <= n_taken;
            r_error   <= n_error;
            r_match   <= n_match;
        end
    end

endmodule

`default_nettype wire

[design/utf8_char_splitter_validator_top.sv]
// UTF-8 character splitter and validator.
// The input channel carries one string byte per transaction, with a flag on
// the last byte of each string. The output channel carries one transaction
// per completed character, first error of a string, or string end (one
// per byte). Bytes that only extend a pending character give none.
// Each byte is decided in the cycle it is accepted; its result is registered
// into the output register, or into the skid register if the receiver stalls.
// One byte can be accepted every cycle while the receiver keeps up.
// Behind the output register sits a one-entry skid register. When the
// receiver stalls, one more result is captured there, and then input is
// stalled until the receiver takes the held result.
// i_cfg_wr_en writes the search character register; bytes accepted after
// the write use it. The user must write it only while idle; nothing checks it.
// Synchronous active-low reset clears the search character, the pending
// character and the string flags, and empties both output registers.
`timescale 1ns / 1ps
`default_nettype none

module utf8_char_splitter_validator_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [31:0]        i_cfg_wr_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire u8v_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output u8v_pkg::t_out_item      o_out_item
);

    logic [31:0]        r_search_char;
    logic               r_out_valid;
    u8v_pkg::t_out_item r_out;
    logic               r_skid_valid;
    u8v_pkg::t_out_item r_skid;

    logic               in_accept;
    logic               out_free;
    logic               res_valid;
    u8v_pkg::t_out_item res;

    assign in_accept   = i_in_valid && !r_skid_valid;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    u8v_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_item        (i_in_item),
        .i_search_char (r_search_char),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_search_char <= 32'd0;
        end else if (i_cfg_wr_en) begin
            r_search_char <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= res_valid;
            end
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else begin
                r_out <= res;
            end
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

endmodule

`default_nettype wire
